// File: hw/rtl/dhp_pkg.sv
// Shared constants, opcodes and controller state type of the duration histogram.
`default_nettype none

package dhp_pkg;

    // Default histogram geometry.
    localparam int DefLinearStep  = 16;
    localparam int DefLinearLimit = 1024;
    localparam int DefLinearBins  = 64;
    localparam int DefTotalBins   = 96;

    // Fixed field widths of the transactions.
    localparam int OpW     = 2;
    localparam int SampleW = 32;
    localparam int FracW   = 17;
    localparam int CountW  = 32;
    localparam int SumW    = 48;
    localparam int InDataW = 56;
    localparam int OutW    = 176;

    // Operation carried in tuser.
    typedef enum logic [OpW-1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } dhp_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BIN,
        ST_ADDR,
        ST_UPDATE,
        ST_QMUL,
        ST_SCAN,
        ST_BOUND,
        ST_DONE
    } dhp_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dhp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module dhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/dhp_bin_index.sv
// Two-step bin index unit: a registered reciprocal multiply and leading-one
// detect, followed by the quotient correction and the bin selection.
`default_nettype none

module dhp_bin_index
    import dhp_pkg::*;
#(
    parameter int LINEAR_STEP  = DefLinearStep,
    parameter int LINEAR_LIMIT = DefLinearLimit,
    parameter int LINEAR_BINS  = DefLinearBins,
    parameter int TOTAL_BINS   = DefTotalBins
) (
    input  wire logic                          clk,
    input  wire logic [SampleW-1:0]            sample,
    output logic      [$clog2(TOTAL_BINS)-1:0] bin
);

    localparam int BinW  = $clog2(TOTAL_BINS);
    localparam int LinW  = $clog2(LINEAR_LIMIT);
    localparam int Base  = $clog2(LINEAR_LIMIT + 1) - 1;
    localparam int KW    = 10;
    localparam int LinMax = (LINEAR_BINS < TOTAL_BINS) ? LINEAR_BINS - 1 : TOTAL_BINS - 1;
    localparam logic [32:0] Recip = 33'((64'd1 << 32) / LINEAR_STEP);

    logic [LinW+32:0] prod;
    logic [4:0]       lead;
    logic [4:0]       lead_m1;
    logic [KW-1:0]    klog;
    logic [KW-1:0]    klog_clamped;

    logic             lin_reg;
    logic [LinW-1:0]  vlow_reg;
    logic [LinW-1:0]  q_reg;
    logic [BinW-1:0]  klog_reg;

    logic [LinW+8:0]  qs;
    logic [LinW+8:0]  rem;
    logic [LinW:0]    qfix;
    logic [BinW-1:0]  klin;

    // Leading one position of the sample.
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < SampleW; i++)
        begin
            if (sample[i])
            begin
                lead = 5'(i);
            end
        end
    end

    // Logarithmic bin: two bins per power of two, split at one and a half.
    always_comb
    begin
        lead_m1      = lead - 5'd1;
        klog         = KW'(LINEAR_BINS) + (KW'(lead - 5'(Base)) << 1) + KW'(sample[lead_m1]);
        klog_clamped = (klog > KW'(TOTAL_BINS - 1)) ? KW'(TOTAL_BINS - 1) : klog;
    end

    // Quotient estimate by reciprocal multiplication, at most one too low.
    assign prod = (LinW + 33)'(sample[LinW-1:0]) * (LinW + 33)'(Recip);

    always_ff @(posedge clk)
    begin
        lin_reg  <= (sample < SampleW'(LINEAR_LIMIT));
        vlow_reg <= sample[LinW-1:0];
        q_reg    <= prod[LinW+31:32];
        klog_reg <= klog_clamped[BinW-1:0];
    end

    // Correct the quotient and pick the bin.
    always_comb
    begin
        qs   = (LinW + 9)'(q_reg) * (LinW + 9)'(LINEAR_STEP);
        rem  = (LinW + 9)'(vlow_reg) - qs;
        qfix = (LinW + 1)'(q_reg) + (LinW + 1)'(rem >= (LinW + 9)'(LINEAR_STEP));
        if (qfix > (LinW + 1)'(LinMax))
        begin
            klin = BinW'(LinMax);
        end
        else
        begin
            klin = BinW'(qfix);
        end
        bin = lin_reg ? klin : klog_reg;
    end

endmodule

`default_nettype wire

// File: hw/rtl/duration_histogram_percentile.sv
// Top level of the duration histogram with percentile query.
//
// Each input transaction carries an operation in tuser: record a sample,
// query a percentile, clear, or no operation; each produces exactly one
// output transaction with the query result and the count, sum, minimum and
// maximum after the operation. The bin counters live in a RAM with a
// registered read, so a record is a read-modify-write of one bin through
// the states ST_BIN, ST_ADDR, ST_UPDATE and ST_DONE. A query with an empty
// histogram, a zero fraction or a fraction of one or more goes straight to
// ST_DONE; any other query walks the bins one per cycle, through ST_QMUL,
// ST_SCAN and ST_BOUND, up to the bin that is found. A clear writes every
// bin once. After reset the block writes zero into all TOTAL_BINS bins before
// s_axis_tready rises. A result waiting in the output register does not stop
// the next transaction from being accepted.
`default_nettype none

module duration_histogram_percentile
    import dhp_pkg::*;
#(
    parameter int LINEAR_STEP  = DefLinearStep,
    parameter int LINEAR_LIMIT = DefLinearLimit,
    parameter int LINEAR_BINS  = DefLinearBins,
    parameter int TOTAL_BINS   = DefTotalBins
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [InDataW-1:0] s_axis_tdata,  // sample_us, fraction, zero fill
    input  wire logic [OpW-1:0]     s_axis_tuser,  // opcode
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [OutW-1:0]    m_axis_tdata   // result_us, sample_count, sum_us,
                                                   // min_us, max_us
);

    localparam int BinW = $clog2(TOTAL_BINS);
    localparam int CumW = CountW + BinW;
    localparam int TgtW = CountW + 1;
    localparam int Base = $clog2(LINEAR_LIMIT + 1) - 1;

    dhp_state_t         state_reg, state_next;
    logic [SampleW-1:0] sample_reg, sample_next;
    logic [FracW-1:0]   frac_reg, frac_next;
    logic [SampleW-1:0] result_reg, result_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic [SumW-1:0]    sum_reg, sum_next;
    logic [SampleW-1:0] min_reg, min_next;
    logic [SampleW-1:0] max_reg, max_next;
    logic [BinW-1:0]    bin_reg, bin_next;
    logic [BinW:0]      rd_idx_reg, rd_idx_next;
    logic               pend_reg, pend_next;
    logic [BinW-1:0]    pend_idx_reg, pend_idx_next;
    logic [CumW-1:0]    cum_reg, cum_next;
    logic [TgtW-1:0]    target_reg, target_next;
    logic [BinW-1:0]    clr_idx_reg, clr_idx_next;
    logic               clr_out_reg, clr_out_next;
    logic               out_valid_reg, out_valid_next;
    logic [OutW-1:0]    out_data_reg, out_data_next;

    logic               in_fire;
    dhp_op_t            op;
    logic [BinW-1:0]    bin_idx;

    logic               mem_we;
    logic [BinW-1:0]    mem_waddr;
    logic [31:0]        mem_wdata;
    logic [BinW-1:0]    mem_raddr;
    logic [31:0]        mem_rdata;

    logic [SumW:0]      sum_ext;
    logic [CumW-1:0]    cum_sum;
    logic [CountW+FracW-1:0] tgt_prod;

    logic [BinW+8:0]    lin_bound;
    logic [BinW-1:0]    bx;
    logic [8:0]         be_raw;
    logic [5:0]         be;
    logic [41:0]        bval;
    logic [31:0]        bound32;

    // Bin index of the held sample.
    dhp_bin_index #(
        .LINEAR_STEP  (LINEAR_STEP),
        .LINEAR_LIMIT (LINEAR_LIMIT),
        .LINEAR_BINS  (LINEAR_BINS),
        .TOTAL_BINS   (TOTAL_BINS)
    ) u_bin_index (
        .clk    (clk),
        .sample (sample_reg),
        .bin    (bin_idx)
    );

    // Bin counter store.
    dhp_ram #(
        .WIDTH (32),
        .DEPTH (TOTAL_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign op            = dhp_op_t'(s_axis_tuser);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Arithmetic helpers for the update, the scan and the target.
    assign sum_ext  = {1'b0, sum_reg} + (SumW + 1)'(sample_reg);
    assign cum_sum  = cum_reg + CumW'(mem_rdata);
    assign tgt_prod = (CountW + FracW)'(count_reg) * (CountW + FracW)'(frac_reg);

    // Upper bound of the bin found by the scan, saturated to 32 bits.
    always_comb
    begin
        lin_bound = ((BinW + 9)'(bin_reg) + (BinW + 9)'(1)) * (BinW + 9)'(LINEAR_STEP);
        bx        = bin_reg - BinW'(LINEAR_BINS);
        be_raw    = 9'(Base) + 9'(bx >> 1);
        be        = (be_raw > 9'd40) ? 6'd40 : be_raw[5:0];
        if (int'(bin_reg) < LINEAR_BINS)
        begin
            bval = 42'(lin_bound);
        end
        else if (!bx[0])
        begin
            bval = (42'd1 << be) + (42'd1 << (be - 6'd1));
        end
        else
        begin
            bval = 42'd1 << (be + 6'd1);
        end
        bound32 = (|bval[41:32]) ? '1 : bval[31:0];
    end

    // Controller: next state, datapath updates and memory control.
    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        frac_next      = frac_reg;
        result_next    = result_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        bin_next       = bin_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        cum_next       = cum_reg;
        target_next    = target_reg;
        clr_idx_next   = clr_idx_reg;
        clr_out_next   = clr_out_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = bin_reg;
        mem_wdata      = '0;
        mem_raddr      = bin_reg;

        // The output register empties when the transaction is taken.
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next = s_axis_tdata[SampleW-1:0];
                    frac_next   = s_axis_tdata[SampleW+FracW-1:SampleW];
                    result_next = '0;
                    case (op)
                        OP_RECORD:
                        begin
                            state_next = ST_BIN;
                        end
                        OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (s_axis_tdata[SampleW+FracW-1:SampleW] == '0)
                            begin
                                result_next = min_reg;
                                state_next  = ST_DONE;
                            end
                            else if (s_axis_tdata[SampleW+FracW-1])
                            begin
                                result_next = max_reg;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_QMUL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            sum_next     = '0;
                            min_next     = '1;
                            max_next     = '0;
                            clr_idx_next = '0;
                            clr_out_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Sweep zero through every bin.
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + BinW'(1);
                if (int'(clr_idx_reg) == TOTAL_BINS - 1)
                begin
                    state_next = clr_out_reg ? ST_DONE : ST_IDLE;
                end
            end

            // Bin index unit works on the held sample.
            ST_BIN:
            begin
                state_next = ST_ADDR;
            end

            ST_ADDR:
            begin
                mem_raddr  = bin_idx;
                bin_next   = bin_idx;
                state_next = ST_UPDATE;
            end

            // Write back the incremented bin and update the running totals.
            ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = bin_reg;
                mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + 32'd1;
                if (count_reg != '1)
                begin
                    count_next = count_reg + CountW'(1);
                end
                sum_next = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
                if (sample_reg < min_reg)
                begin
                    min_next = sample_reg;
                end
                if (sample_reg > max_reg)
                begin
                    max_next = sample_reg;
                end
                state_next = ST_DONE;
            end

            // Target count and scan set-up.
            ST_QMUL:
            begin
                target_next = tgt_prod[CountW+FracW-1:16];
                rd_idx_next = '0;
                pend_next   = 1'b0;
                cum_next    = '0;
                state_next  = ST_SCAN;
            end

            // One bin read per cycle, accumulated in the cycle after its read.
            ST_SCAN:
            begin
                mem_raddr = rd_idx_reg[BinW-1:0];
                if (int'(rd_idx_reg) < TOTAL_BINS)
                begin
                    rd_idx_next   = rd_idx_reg + (BinW + 1)'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[BinW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    cum_next = cum_sum;
                    if (cum_sum >= CumW'(target_reg))
                    begin
                        bin_next   = pend_idx_reg;
                        state_next = ST_BOUND;
                    end
                end
                else if (int'(rd_idx_reg) >= TOTAL_BINS)
                begin
                    result_next = max_reg;
                    state_next  = ST_DONE;
                end
            end

            ST_BOUND:
            begin
                result_next = (bound32 < max_reg) ? bound32 : max_reg;
                state_next  = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {max_reg, min_reg, sum_reg, count_reg, result_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and totals registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            clr_idx_reg   <= '0;
            clr_out_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            clr_idx_reg   <= clr_idx_next;
            clr_out_reg   <= clr_out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        frac_reg     <= frac_next;
        result_reg   <= result_next;
        bin_reg      <= bin_next;
        pend_idx_reg <= pend_idx_next;
        cum_reg      <= cum_next;
        target_reg   <= target_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
